// ===== rtl/core/pep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pep_pkg
// shared widths, angle constants and the arctangent table for the polygon
// edge face unit
// ----------------------------------------------------------------------------
package pep_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 18;

    localparam int COORD_W = 32;
    localparam int ANG_W   = FRAC_BITS + 3;
    localparam int UNIT_W  = FRAC_BITS + 2;
    localparam int LEN_W   = 33;
    localparam int DIFF_W  = 33;
    localparam int UV_W    = 44;
    localparam int Z_W     = 36;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int REM_W   = LEN_W + 4;
    localparam int CNT_W   = 6;
    localparam int SH      = 30 - FRAC_BITS;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] LEN_LAST  = CNT_W'(LEN_W - 1);

    localparam logic signed [Z_W-1:0] PI_Q30         = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30    = 36'sd1686629713;
    localparam logic signed [Z_W-1:0] THREE_HALF_Q30 = 36'sd5059889139;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30     = 36'sd6746518852;
    localparam logic signed [UV_W-1:0] INV_GAIN_Q30  = 44'sd652032874;

    localparam logic signed [Z_W-1:0] Q30_HALF = Z_W'(64'sd1 <<< (SH - 1));
    localparam logic signed [Z_W-1:0] PI_OUT     = (PI_Q30 + Q30_HALF) >>> SH;
    localparam logic signed [Z_W-1:0] TWO_PI_OUT = (TWO_PI_Q30 + Q30_HALF) >>> SH;
    localparam logic signed [UV_W-1:0] UNIT_ONE  = UV_W'(64'sd1 <<< FRAC_BITS);

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] k);
        logic signed [Z_W-1:0] r;
        case (k)
            5'd0:  r = 36'sh03243F6A8;
            5'd1:  r = 36'sh01DAC6705;
            5'd2:  r = 36'sh00FADBAFC;
            5'd3:  r = 36'sh007F56EA6;
            5'd4:  r = 36'sh003FEAB76;
            5'd5:  r = 36'sh001FFD55B;
            5'd6:  r = 36'sh000FFFAAA;
            5'd7:  r = 36'sh0007FFF55;
            5'd8:  r = 36'sh0003FFFEA;
            5'd9:  r = 36'sh0001FFFFD;
            5'd10: r = 36'sh0000FFFFF;
            5'd11: r = 36'sh00007FFFF;
            5'd12: r = 36'sh00003FFFF;
            5'd13: r = 36'sh00001FFFF;
            5'd14: r = 36'sh00000FFFF;
            5'd15: r = 36'sh000007FFF;
            5'd16: r = 36'sh000003FFF;
            5'd17: r = 36'sh000001FFF;
            5'd18: r = 36'sh000000FFF;
            5'd19: r = 36'sh0000007FF;
            5'd20: r = 36'sh0000003FF;
            5'd21: r = 36'sh0000001FF;
            5'd22: r = 36'sh0000000FF;
            5'd23: r = 36'sh00000007F;
            5'd24: r = 36'sh00000003F;
            5'd25: r = 36'sh00000001F;
            5'd26: r = 36'sh00000000F;
            5'd27: r = 36'sh000000008;
            5'd28: r = 36'sh000000004;
            5'd29: r = 36'sh000000002;
            5'd30: r = 36'sh000000001;
            default: r = 36'sh000000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/polygon_edge_faces.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_edge_faces
// streams polygon vertices and emits angle, sine, cosine, length and normal
// of every edge, closing the polygon on the last vertex
// ----------------------------------------------------------------------------
// A vertex is taken only while the sequencer is idle. Each face runs a
// setup step, normalize shifts, CORDIC vectoring iterations, an angle step,
// CORDIC rotation iterations, shift-add squaring, a bit-serial square root
// and an output step, in that order, all on one shared shift-add datapath;
// a zero-length face goes straight from setup to output. A closing vertex
// that follows another runs two faces back to back, and a vertex that emits
// no face is taken without leaving idle. A finished face waits in the output
// register while the next one is worked on, and the output step stalls until
// that register is free.
module polygon_edge_faces (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [pep_pkg::COORD_W-1:0]   s_vertex_x,
    input  wire logic signed [pep_pkg::COORD_W-1:0]   s_vertex_y,
    input  wire logic                                 s_last_vertex,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic        [pep_pkg::ANG_W-1:0]          m_face_angle,
    output logic signed [pep_pkg::UNIT_W-1:0]         m_face_sine,
    output logic signed [pep_pkg::UNIT_W-1:0]         m_face_cosine,
    output logic        [pep_pkg::LEN_W-1:0]          m_face_length,
    output logic signed [pep_pkg::UNIT_W-1:0]         m_normal_x,
    output logic signed [pep_pkg::UNIT_W-1:0]         m_normal_y,
    output logic                                      m_last_face
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_NORM  = 4'd2;
    localparam logic [3:0] ST_VEC   = 4'd3;
    localparam logic [3:0] ST_ANG   = 4'd4;
    localparam logic [3:0] ST_ROT   = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int UV_W  = pep_pkg::UV_W;
    localparam int Z_W   = pep_pkg::Z_W;
    localparam int LEN_W = pep_pkg::LEN_W;
    localparam int SQ_W  = pep_pkg::SQ_W;
    localparam int REM_W = pep_pkg::REM_W;

    logic [3:0] state_reg;
    logic       have_first_reg, edge_pend_reg, close_pend_reg;
    logic       closing_reg, zero_reg, flip_reg, neg_reg;
    logic signed [pep_pkg::COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [pep_pkg::COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [pep_pkg::COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [UV_W-1:0] u_reg, v_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [pep_pkg::ANG_W-1:0] oang_reg;
    logic [pep_pkg::CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0] ax_reg, ay_reg, root_reg;
    logic [SQ_W-1:0]  mx_reg, my_reg, acc_reg;
    logic [REM_W-1:0] rem_reg;

    // datapath
    logic signed [pep_pkg::DIFF_W-1:0] dx, dy;
    logic signed [UV_W-1:0] u0, v0, absv, mag, su, sv, sx;
    logic signed [Z_W-1:0]  atn, a0, a1, a2, oa, rr;
    logic [4:0] k;
    logic [REM_W-1:0] rem_sh, trial;
    logic [LEN_W-1:0] len_out;
    logic signed [UV_W-1:0] xr, yr, cq, sq;
    logic signed [pep_pkg::UNIT_W-1:0] cos_out, sin_out;

    always_comb begin
        if (edge_pend_reg) begin
            dx = pep_pkg::DIFF_W'(cur_x_reg) - pep_pkg::DIFF_W'(prev_x_reg);
            dy = pep_pkg::DIFF_W'(cur_y_reg) - pep_pkg::DIFF_W'(prev_y_reg);
        end else begin
            dx = pep_pkg::DIFF_W'(first_x_reg) - pep_pkg::DIFF_W'(cur_x_reg);
            dy = pep_pkg::DIFF_W'(first_y_reg) - pep_pkg::DIFF_W'(cur_y_reg);
        end
        u0 = -UV_W'(dx);
        v0 = -UV_W'(dy);
        absv = v_reg[UV_W-1] ? -v_reg : v_reg;
        mag = (u_reg > absv) ? u_reg : absv;
        k = cnt_reg[4:0];
        atn = pep_pkg::atan_q30(k);
        su = u_reg >>> k;
        sv = v_reg >>> k;
        a0 = (flip_reg ? pep_pkg::PI_Q30 : '0) + z_reg;
        a1 = a0[Z_W-1] ? a0 + pep_pkg::TWO_PI_Q30 : a0;
        a2 = (a1 >= pep_pkg::TWO_PI_Q30) ? a1 - pep_pkg::TWO_PI_Q30 : a1;
        oa = (a2 + pep_pkg::Q30_HALF) >>> pep_pkg::SH;
        if (oa >= pep_pkg::TWO_PI_OUT) begin
            oa = oa - pep_pkg::TWO_PI_OUT;
        end
        rr = a2;
        if (a2 > pep_pkg::HALF_PI_Q30 && a2 <= pep_pkg::THREE_HALF_Q30) begin
            rr = a2 - pep_pkg::PI_Q30;
        end else if (a2 > pep_pkg::THREE_HALF_Q30) begin
            rr = a2 - pep_pkg::TWO_PI_Q30;
        end
        sx = u_reg >>> k;
        rem_sh = {rem_reg[REM_W-3:0], acc_reg[SQ_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        len_out = (rem_reg > {4'b0000, root_reg}) ? root_reg + 1'b1 : root_reg;
        xr = neg_reg ? -u_reg : u_reg;
        yr = neg_reg ? -v_reg : v_reg;
        cq = (xr + UV_W'(pep_pkg::Q30_HALF)) >>> pep_pkg::SH;
        sq = (yr + UV_W'(pep_pkg::Q30_HALF)) >>> pep_pkg::SH;
        if (cq > pep_pkg::UNIT_ONE) cq = pep_pkg::UNIT_ONE;
        if (cq < -pep_pkg::UNIT_ONE) cq = -pep_pkg::UNIT_ONE;
        if (sq > pep_pkg::UNIT_ONE) sq = pep_pkg::UNIT_ONE;
        if (sq < -pep_pkg::UNIT_ONE) sq = -pep_pkg::UNIT_ONE;
        cos_out = cq[pep_pkg::UNIT_W-1:0];
        sin_out = sq[pep_pkg::UNIT_W-1:0];
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            have_first_reg <= 1'b0;
            edge_pend_reg <= 1'b0;
            close_pend_reg <= 1'b0;
            m_valid <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else begin
            if (m_valid && m_ready && (state_reg != ST_DONE)) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_x_reg <= s_vertex_x;
                        cur_y_reg <= s_vertex_y;
                        if (!have_first_reg) begin
                            first_x_reg <= s_vertex_x;
                            first_y_reg <= s_vertex_y;
                        end
                        edge_pend_reg <= have_first_reg;
                        close_pend_reg <= s_last_vertex;
                        have_first_reg <= !s_last_vertex;
                        if (have_first_reg || s_last_vertex) begin
                            state_reg <= ST_SETUP;
                        end else begin
                            prev_x_reg <= s_vertex_x;
                            prev_y_reg <= s_vertex_y;
                        end
                    end
                end
                ST_SETUP: begin
                    closing_reg <= !edge_pend_reg;
                    if (edge_pend_reg) edge_pend_reg <= 1'b0;
                    else close_pend_reg <= 1'b0;
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    zero_reg <= (dx == '0) && (dy == '0);
                    flip_reg <= u0[UV_W-1];
                    u_reg <= u0[UV_W-1] ? -u0 : u0;
                    v_reg <= u0[UV_W-1] ? -v0 : v0;
                    ax_reg <= dx[pep_pkg::DIFF_W-1] ? LEN_W'(-dx) : LEN_W'(dx);
                    ay_reg <= dy[pep_pkg::DIFF_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
                    z_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ((dx == '0) && (dy == '0)) ? ST_DONE : ST_NORM;
                end
                ST_NORM: begin
                    if (mag < (UV_W'(1) <<< 31)) begin
                        u_reg <= u_reg <<< 8;
                        v_reg <= v_reg <<< 8;
                    end else if (mag < (UV_W'(1) <<< 39)) begin
                        u_reg <= u_reg <<< 1;
                        v_reg <= v_reg <<< 1;
                    end else begin
                        state_reg <= ST_VEC;
                    end
                end
                ST_VEC: begin
                    if (v_reg > 0) begin
                        u_reg <= u_reg + sv;
                        v_reg <= v_reg - su;
                        z_reg <= z_reg + atn;
                    end else begin
                        u_reg <= u_reg - sv;
                        v_reg <= v_reg + su;
                        z_reg <= z_reg - atn;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pep_pkg::LAST_STEP) state_reg <= ST_ANG;
                end
                ST_ANG: begin
                    oang_reg <= oa[pep_pkg::ANG_W-1:0];
                    z_reg <= rr;
                    neg_reg <= (a2 > pep_pkg::HALF_PI_Q30)
                        && (a2 <= pep_pkg::THREE_HALF_Q30);
                    u_reg <= pep_pkg::INV_GAIN_Q30;
                    v_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (!z_reg[Z_W-1]) begin
                        u_reg <= u_reg - sv;
                        v_reg <= v_reg + sx;
                        z_reg <= z_reg - atn;
                    end else begin
                        u_reg <= u_reg + sv;
                        v_reg <= v_reg - sx;
                        z_reg <= z_reg + atn;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pep_pkg::LAST_STEP) begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        mx_reg <= SQ_W'(ax_reg);
                        my_reg <= SQ_W'(ay_reg);
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    acc_reg <= acc_reg + (ax_reg[0] ? mx_reg : '0)
                        + (ay_reg[0] ? my_reg : '0);
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pep_pkg::LEN_LAST) begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        root_reg <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    acc_reg <= acc_reg << 2;
                    if (rem_sh >= trial) begin
                        rem_reg <= rem_sh - trial;
                        root_reg <= {root_reg[LEN_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[LEN_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pep_pkg::LEN_LAST) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_last_face <= closing_reg;
                        if (zero_reg) begin
                            m_face_angle <= pep_pkg::PI_OUT[pep_pkg::ANG_W-1:0];
                            m_face_sine <= '0;
                            m_face_cosine <= -(pep_pkg::UNIT_ONE[pep_pkg::UNIT_W-1:0]);
                            m_face_length <= '0;
                            m_normal_x <= '0;
                            m_normal_y <= pep_pkg::UNIT_ONE[pep_pkg::UNIT_W-1:0];
                        end else begin
                            m_face_angle <= oang_reg;
                            m_face_sine <= sin_out;
                            m_face_cosine <= cos_out;
                            m_face_length <= len_out;
                            m_normal_x <= sin_out;
                            m_normal_y <= -cos_out;
                        end
                        state_reg <= (edge_pend_reg || close_pend_reg) ? ST_SETUP : ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (Z_W'(m_face_angle) < pep_pkg::TWO_PI_OUT))
        else $error("face angle out of range");
    a_normal_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_y == -m_face_cosine) && (m_normal_x == m_face_sine))
        else $error("normal does not match sine and cosine");
    a_zero_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_face_length == '0)) |-> (m_face_sine == '0))
        else $error("zero length face with nonzero sine");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |-> (edge_pend_reg || close_pend_reg))
        else $error("face setup with no pending face");

endmodule
`default_nettype wire
